### design/array_double_ended_queue_defines.svh
// Assertion macros shared by the double-ended queue RTL.
`ifndef ARRAY_DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define ARRAY_DOUBLE_ENDED_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked check, switched off while reset is asserted.
`define ADQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Clocked check that also holds during reset.
`define ADQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ADQ_ASSERT(lbl, prop, msg)
`define ADQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### design/adq_pkg.sv
// Package with the types and constants of the double-ended queue.
`timescale 1ns / 1ps
package adq_pkg;

  // Storage geometry.
  localparam int unsigned Depth = 16;
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned WordW = 32;
  localparam int unsigned OpW   = 3;
  localparam int unsigned StatW = 2;
  localparam int unsigned CntOutW = 5;
  // Internal count width: wide enough for Depth and for the output field.
  localparam int unsigned CntW  = (IdxW + 1 > CntOutW) ? IdxW + 1 : CntOutW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);

  typedef logic [IdxW-1:0] idx_t;
  typedef logic signed [WordW-1:0] word_t;

  // Operation codes of a request beat.
  typedef enum logic [OpW-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_QUERY      = 3'd4
  } op_e;

  // Status codes of a response beat.
  typedef enum logic [StatW-1:0] {
    ST_DONE  = 2'd0,
    ST_OVER  = 2'd1,
    ST_UNDER = 2'd2
  } status_e;

  // Control sequencer states.
  typedef enum logic {
    S_IDLE,
    S_LOOKUP
  } state_e;

endpackage

### design/adq_req_if.sv
// Request channel of the double-ended queue.
`timescale 1ns / 1ps
interface adq_req_if;
  logic                     valid;
  logic                     ready;
  logic [adq_pkg::OpW-1:0]  op;
  adq_pkg::word_t           value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

### design/adq_rsp_if.sv
// Response channel of the double-ended queue.
`timescale 1ns / 1ps
interface adq_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [adq_pkg::StatW-1:0]    status;
  adq_pkg::word_t               front_value;
  logic [adq_pkg::CntOutW-1:0]  count;
  logic                         is_empty;

  modport source (output valid, output status, output front_value, output count,
                  output is_empty, input ready);
  modport sink   (input valid, input status, input front_value, input count,
                  input is_empty, output ready);
endinterface

### design/array_double_ended_queue.sv
// Double-ended queue over a fixed, non-circular word array.
//
// Usage: requests arrive on req_i (op, value) and every request beat gives
// exactly one response beat on rsp_o (status, front_value, count, is_empty).
// Both channels use valid/ready; a beat moves when both are high.
// Ops: push back, push front, pop front, pop back and query; other codes
// behave as a query. Refused pushes report overflow, pops on an empty queue
// report underflow, and neither changes the contents.
// Timing: the request beat moves the sequencer into the lookup state, and
// the lookup state loads the response registers and raises rsp_o.valid.
// A request is handled in two steps. The update step changes the indices
// and writes the slot, the lookup step takes the registered read of the
// word at the head out of the slot RAM, which has registered read data.
// A new request is taken while the previous response is being handed over,
// but not while the lookup step is running.
// Reset: the queue comes up empty with both indices at zero; the slot words
// need no clearing, as only written slots are ever read.
// Stall: while a response waits on rsp_o, no new request is taken.
`timescale 1ns / 1ps
`include "array_double_ended_queue_defines.svh"
module array_double_ended_queue (
  input  logic      clk_i,
  input  logic      rst_ni,
  adq_req_if.sink   req_i,
  adq_rsp_if.source rsp_o
);

  adq_pkg::state_e  state_q, state_d;
  adq_pkg::idx_t    head_q, head_d;
  adq_pkg::idx_t    tail_q, tail_d;
  logic             empty_q, empty_d;
  logic             out_valid_q, out_valid_d;

  // Values held between the update cycle and the read-out cycle.
  adq_pkg::status_e pend_status_q, pend_status_d;
  logic             fwd_q, fwd_d;
  adq_pkg::word_t   fwd_val_q;

  // Response payload registers.
  logic [adq_pkg::StatW-1:0]   rsp_status_q;
  adq_pkg::word_t              rsp_front_q;
  logic [adq_pkg::CntOutW-1:0] rsp_count_q;
  logic                        rsp_empty_q;

  logic                        accept;
  logic                        load_rsp;
  logic                        we;
  adq_pkg::idx_t               waddr;
  adq_pkg::word_t              rdata;
  adq_pkg::word_t              front_sel;
  logic [adq_pkg::CntW-1:0]    cnt;

  // Slot storage.
  adq_ram #(
    .Width (adq_pkg::WordW),
    .Depth (adq_pkg::Depth)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (req_i.value),
    .re_i    (accept),
    .raddr_i (head_d),
    .rdata_o (rdata)
  );

  // Request is taken when idle and the response register is free or freeing.
  assign req_i.ready = (state_q == adq_pkg::S_IDLE) && (!out_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;
  assign load_rsp    = (state_q == adq_pkg::S_LOOKUP);

  // Next state, index update and slot write.
  always_comb begin
    state_d       = state_q;
    head_d        = head_q;
    tail_d        = tail_q;
    empty_d       = empty_q;
    pend_status_d = pend_status_q;
    fwd_d         = fwd_q;
    we            = 1'b0;
    waddr         = '0;
    out_valid_d   = out_valid_q;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      adq_pkg::S_IDLE: begin
        if (accept) begin
          state_d       = adq_pkg::S_LOOKUP;
          pend_status_d = adq_pkg::ST_DONE;
          fwd_d         = 1'b0;
          unique case (req_i.op)
            adq_pkg::OP_PUSH_BACK: begin
              if (empty_q) begin
                head_d  = '0;
                tail_d  = '0;
                empty_d = 1'b0;
                we      = 1'b1;
                waddr   = '0;
                fwd_d   = 1'b1;
              end else if (tail_q == adq_pkg::LastIdx) begin
                pend_status_d = adq_pkg::ST_OVER;
              end else begin
                tail_d = tail_q + 1'b1;
                we     = 1'b1;
                waddr  = tail_q + 1'b1;
              end
            end
            adq_pkg::OP_PUSH_FRONT: begin
              if (empty_q) begin
                head_d  = '0;
                tail_d  = '0;
                empty_d = 1'b0;
                we      = 1'b1;
                waddr   = '0;
                fwd_d   = 1'b1;
              end else if (head_q == '0) begin
                pend_status_d = adq_pkg::ST_OVER;
              end else begin
                head_d = head_q - 1'b1;
                we     = 1'b1;
                waddr  = head_q - 1'b1;
                fwd_d  = 1'b1;
              end
            end
            adq_pkg::OP_POP_FRONT: begin
              if (empty_q) begin
                pend_status_d = adq_pkg::ST_UNDER;
              end else if (head_q == tail_q) begin
                head_d  = '0;
                tail_d  = '0;
                empty_d = 1'b1;
              end else begin
                head_d = head_q + 1'b1;
              end
            end
            adq_pkg::OP_POP_BACK: begin
              if (empty_q) begin
                pend_status_d = adq_pkg::ST_UNDER;
              end else if (head_q == tail_q) begin
                head_d  = '0;
                tail_d  = '0;
                empty_d = 1'b1;
              end else begin
                tail_d = tail_q - 1'b1;
              end
            end
            default: begin
              // Query and unused codes leave the queue as it is.
            end
          endcase
        end
      end
      adq_pkg::S_LOOKUP: begin
        state_d     = adq_pkg::S_IDLE;
        out_valid_d = 1'b1;
      end
      default: begin
        state_d = adq_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= adq_pkg::S_IDLE;
      head_q        <= '0;
      tail_q        <= '0;
      empty_q       <= 1'b1;
      out_valid_q   <= 1'b0;
      pend_status_q <= adq_pkg::ST_DONE;
      fwd_q         <= 1'b0;
    end else begin
      state_q       <= state_d;
      head_q        <= head_d;
      tail_q        <= tail_d;
      empty_q       <= empty_d;
      out_valid_q   <= out_valid_d;
      pend_status_q <= pend_status_d;
      fwd_q         <= fwd_d;
    end
  end

  // Front word: -1 when the queue is empty, else the pushed word when it landed at the head, else the RAM read.
  assign front_sel = empty_q ? adq_pkg::word_t'(-1) : (fwd_q ? fwd_val_q : rdata);
  assign cnt = empty_q ? '0
             : adq_pkg::CntW'(tail_q) - adq_pkg::CntW'(head_q) + adq_pkg::CntW'(1);

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      fwd_val_q <= req_i.value;
    end
    if (load_rsp) begin
      rsp_status_q <= pend_status_q;
      rsp_front_q  <= front_sel;
      rsp_count_q  <= cnt[adq_pkg::CntOutW-1:0];
      rsp_empty_q  <= empty_q;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.front_value = rsp_front_q;
  assign rsp_o.count       = rsp_count_q;
  assign rsp_o.is_empty    = rsp_empty_q;

  // Checks on the sequencer and the index pair.
  `ADQ_ASSERT(a_head_le_tail, head_q <= tail_q, "head index passed tail index")
  `ADQ_ASSERT(a_empty_zero, empty_q |-> (head_q == '0 && tail_q == '0),
              "empty queue with indices off zero")
  `ADQ_ASSERT(a_accept_lookup, accept |=> (state_q == adq_pkg::S_LOOKUP),
              "request beat not followed by lookup")
  `ADQ_ASSERT(a_lookup_valid, (state_q == adq_pkg::S_LOOKUP) |=> out_valid_q,
              "lookup did not produce a response beat")
  `ADQ_ASSERT_ALWAYS(a_no_accept_busy, (state_q == adq_pkg::S_LOOKUP) |-> !req_i.ready,
                     "request taken during lookup")

endmodule

### design/adq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module adq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; a read of the address being written returns the old word.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
